>>> rtl/sorxu_pkg.sv
package sorxu_pkg;

    typedef enum logic [3:0] {
        CMD_MOVE  = 4'd0,
        CMD_NOT   = 4'd1,
        CMD_AND   = 4'd2,
        CMD_OR    = 4'd3,
        CMD_ADD   = 4'd4,
        CMD_SUB   = 4'd5,
        CMD_ADDI  = 4'd6,
        CMD_SUBI  = 4'd7,
        CMD_SET   = 4'd8,
        CMD_SETH  = 4'd9,
        CMD_INCIZ = 4'd10,
        CMD_DECIN = 4'd11,
        CMD_MOVEZ = 4'd12,
        CMD_MOVEX = 4'd13,
        CMD_MOVEP = 4'd14,
        CMD_MOVEN = 4'd15
    } cmd_t;

    localparam int FIELD_IDX_BITS = 4;
    localparam int IMM_BITS       = 8;
    localparam int IMM4_BITS      = 4;
    localparam int OUT_WORD_BITS  = 16;

    typedef struct packed {
        logic [3:0]                command;
        logic [FIELD_IDX_BITS-1:0] dest_reg;
        logic [FIELD_IDX_BITS-1:0] src_a_reg;
        logic [FIELD_IDX_BITS-1:0] src_b_reg;
        logic [IMM_BITS-1:0]       immediate;
    } instr_t;

    typedef struct packed {
        logic                      wrote;
        logic [FIELD_IDX_BITS-1:0] written_reg;
        logic [OUT_WORD_BITS-1:0]  written_value;
    } result_t;

    typedef struct packed {
        logic load;
        logic latch_ab;
        logic commit;
    } ctrl_cmd_t;

endpackage

>>> rtl/sorxu_ram.sv
module sorxu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re0,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    output logic [WIDTH-1:0]         rdata0,
    input  logic                     re1,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re0)
        begin
            rdata0 <= mem[raddr0];
        end
        if (re1)
        begin
            rdata1 <= mem[raddr1];
        end
    end

endmodule

>>> rtl/sorxu_ctrl.sv
module sorxu_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                instr_valid,
    output logic                instr_ready,
    output logic                result_valid,
    input  logic                result_ready,
    output sorxu_pkg::ctrl_cmd_t cmd
);
    import sorxu_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ_D,
        S_EXEC
    } state_t;

    state_t state_reg;
    logic   result_valid_reg;

    assign instr_ready  = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;

    always_comb
    begin
        cmd.load     = instr_valid && (state_reg == S_IDLE);
        cmd.latch_ab = (state_reg == S_READ_D);
        cmd.commit   = (state_reg == S_EXEC) && (!result_valid_reg || result_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd.load)
                    begin
                        state_reg <= S_READ_D;
                    end
                end
                S_READ_D:
                begin
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    if (cmd.commit)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (cmd.commit)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_load_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !instr_ready && cmd.latch_ab)
        else $error("accepted beat did not start the read sequence");

    a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> result_valid && instr_ready)
        else $error("commit did not present a result");

    a_stall_holds_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) && result_valid && !result_ready |=>
        (state_reg == S_EXEC) && result_valid)
        else $error("execute left while result was stalled");
`endif

endmodule

>>> rtl/sorxu_datapath.sv
module sorxu_datapath #(
    parameter int NUM_REGS  = 16,
    parameter int WORD_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sorxu_pkg::ctrl_cmd_t cmd,
    input  sorxu_pkg::instr_t    instr,
    output sorxu_pkg::result_t   result
);
    import sorxu_pkg::*;

    localparam int IDX_BITS  = $clog2(NUM_REGS);
    localparam int HALF_BITS = WORD_BITS / 2;

    function automatic logic [IDX_BITS-1:0] reduce_idx(input logic [FIELD_IDX_BITS-1:0] f);
        logic [6:0] v;
        v = 7'(f);
        for (int i = 0; i < 8; i++)
        begin
            if (v >= 7'(NUM_REGS))
            begin
                v = v - 7'(NUM_REGS);
            end
        end
        return IDX_BITS'(v);
    endfunction

    instr_t                instr_reg;
    logic [IDX_BITS-1:0]   d_idx_reg;
    logic [WORD_BITS-1:0]  a_reg;
    logic [NUM_REGS-1:0]   valid_reg;
    logic                  vld0_reg;
    logic                  vld1_reg;
    result_t               result_reg;

    logic [IDX_BITS-1:0]   ia;
    logic [IDX_BITS-1:0]   ib;
    logic [IDX_BITS-1:0]   addr0;
    logic                  re0;
    logic [WORD_BITS-1:0]  rdata0;
    logic [WORD_BITS-1:0]  rdata1;
    logic [WORD_BITS-1:0]  b_val;
    logic [WORD_BITS-1:0]  old;
    logic [WORD_BITS-1:0]  imm4;
    logic [WORD_BITS-1:0]  imm8;
    logic [WORD_BITS-1:0]  half_mask;
    logic [WORD_BITS-1:0]  val;
    logic [WORD_BITS-1:0]  new_val;
    logic                  wr;
    logic                  b_zero;
    logic                  b_neg;

    assign ia    = reduce_idx(instr.src_a_reg);
    assign ib    = reduce_idx(instr.src_b_reg);
    assign addr0 = cmd.load ? ia : d_idx_reg;
    assign re0   = cmd.load || cmd.latch_ab;

    sorxu_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_REGS)
    ) u_regfile (
        .clk    (clk),
        .we     (cmd.commit && wr),
        .waddr  (d_idx_reg),
        .wdata  (val),
        .re0    (re0),
        .raddr0 (addr0),
        .rdata0 (rdata0),
        .re1    (cmd.load),
        .raddr1 (ib),
        .rdata1 (rdata1)
    );

    assign b_val     = vld1_reg ? rdata1 : '0;
    assign old       = vld0_reg ? rdata0 : '0;
    assign imm4      = WORD_BITS'(instr_reg.immediate[IMM4_BITS-1:0]);
    assign imm8      = WORD_BITS'(instr_reg.immediate);
    assign half_mask = {WORD_BITS{1'b1}} >> (WORD_BITS - HALF_BITS);
    assign b_zero    = (b_val == '0);
    assign b_neg     = b_val[WORD_BITS-1];

    always_comb
    begin
        val = old;
        wr  = 1'b1;
        case (cmd_t'(instr_reg.command))
            CMD_MOVE:  val = a_reg;
            CMD_NOT:   val = ~a_reg;
            CMD_AND:   val = a_reg & b_val;
            CMD_OR:    val = a_reg | b_val;
            CMD_ADD:   val = a_reg + b_val;
            CMD_SUB:   val = a_reg - b_val;
            CMD_ADDI:  val = a_reg + imm4;
            CMD_SUBI:  val = a_reg - imm4;
            CMD_SET:   val = imm8;
            CMD_SETH:  val = (old & half_mask)
                           | (WORD_BITS'(HALF_BITS'(instr_reg.immediate)) << HALF_BITS);
            CMD_INCIZ:
            begin
                wr  = b_zero;
                val = old + imm4;
            end
            CMD_DECIN:
            begin
                wr  = b_neg;
                val = old - imm4;
            end
            CMD_MOVEZ:
            begin
                wr  = b_zero;
                val = a_reg;
            end
            CMD_MOVEX:
            begin
                wr  = !b_zero;
                val = a_reg;
            end
            CMD_MOVEP:
            begin
                wr  = !b_neg;
                val = a_reg;
            end
            CMD_MOVEN:
            begin
                wr  = b_neg;
                val = a_reg;
            end
            default:
            begin
                wr  = b_neg;
                val = a_reg;
            end
        endcase
    end

    assign new_val = wr ? val : old;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.commit && wr)
        begin
            valid_reg[d_idx_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            instr_reg <= instr;
            d_idx_reg <= reduce_idx(instr.dest_reg);
            vld1_reg  <= valid_reg[ib];
        end
        if (re0)
        begin
            vld0_reg <= valid_reg[addr0];
        end
        if (cmd.latch_ab)
        begin
            a_reg <= old;
        end
        if (cmd.commit)
        begin
            result_reg.wrote         <= wr;
            result_reg.written_reg   <= FIELD_IDX_BITS'(d_idx_reg);
            result_reg.written_value <= OUT_WORD_BITS'(new_val);
        end
    end

    assign result = result_reg;

`ifndef SYNTHESIS
    a_write_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && wr |=> valid_reg[$past(d_idx_reg)])
        else $error("written register not marked valid");

    a_result_flag: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> result_reg.wrote == $past(wr))
        else $error("result flag differs from write enable");

    a_skip_keeps_old: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && !wr |=> result_reg.written_value == $past(OUT_WORD_BITS'(old)))
        else $error("skipped write reported a changed value");
`endif

endmodule

>>> rtl/sixteen_op_register_execute_unit_top.sv
// Channel  Signals                                   Payload
// instr    instr_valid / instr_ready / instr         command, dest_reg, src_a_reg,
//                                                    src_b_reg, immediate
// result   result_valid / result_ready / result      wrote, written_reg, written_value
//
// An instruction is accepted only after the previous one commits, and its result
// beat is registered at commit after states READ_D and EXEC: the register file
// RAM has two read ports, so A and B are read first and D is read next.
// One instruction is in flight at a time; instr_ready is high only when idle.
// A result stalled on result_ready holds the next instruction in execute.
// Reset clears the register file through per-register valid bits, at once.
module sixteen_op_register_execute_unit_top #(
    parameter int NUM_REGS  = 16,
    parameter int WORD_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               instr_valid,
    output logic               instr_ready,
    input  sorxu_pkg::instr_t  instr,
    output logic               result_valid,
    input  logic               result_ready,
    output sorxu_pkg::result_t result
);
    import sorxu_pkg::*;

    ctrl_cmd_t cmd;

    sorxu_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .instr_valid  (instr_valid),
        .instr_ready  (instr_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd)
    );

    sorxu_datapath #(
        .NUM_REGS  (NUM_REGS),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .instr  (instr),
        .result (result)
    );

endmodule

>>> tb/execute_result_check.sv
`timescale 1ns / 1ps

module execute_result_check (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               instr_valid,
    input  logic               instr_ready,
    input  sorxu_pkg::instr_t  instr,
    input  logic               result_valid,
    input  logic               result_ready,
    input  sorxu_pkg::result_t result,
    output int                 mismatches,
    output int                 writebacks_pending
);
    import sorxu_pkg::*;

    localparam int WORD = 16;
    localparam int HALF = WORD / 2;

    logic [WORD-1:0] reg_copy [16];
    result_t         expected_writebacks [$];

    function automatic result_t execute_instr(input instr_t ins);
        cmd_t            op;
        logic [WORD-1:0] a;
        logic [WORD-1:0] b;
        logic [WORD-1:0] d_old;
        logic [WORD-1:0] val;
        logic [3:0]      imm4;
        logic            wr;
        result_t         res;
        op    = cmd_t'(ins.command);
        a     = reg_copy[ins.src_a_reg];
        b     = reg_copy[ins.src_b_reg];
        d_old = reg_copy[ins.dest_reg];
        imm4  = ins.immediate[3:0];
        val   = d_old;
        wr    = 1'b1;
        case (op)
            CMD_MOVE:  val = a;
            CMD_NOT:   val = ~a;
            CMD_AND:   val = a & b;
            CMD_OR:    val = a | b;
            CMD_ADD:   val = a + b;
            CMD_SUB:   val = a - b;
            CMD_ADDI:  val = a + WORD'(imm4);
            CMD_SUBI:  val = a - WORD'(imm4);
            CMD_SET:   val = WORD'(ins.immediate);
            CMD_SETH:  val = {ins.immediate[HALF-1:0], d_old[HALF-1:0]};
            CMD_INCIZ:
            begin
                wr = (b == '0);
                if (wr) val = d_old + WORD'(imm4);
            end
            CMD_DECIN:
            begin
                wr = b[WORD-1];
                if (wr) val = d_old - WORD'(imm4);
            end
            CMD_MOVEZ:
            begin
                wr = (b == '0);
                if (wr) val = a;
            end
            CMD_MOVEX:
            begin
                wr = (b != '0);
                if (wr) val = a;
            end
            CMD_MOVEP:
            begin
                wr = !b[WORD-1];
                if (wr) val = a;
            end
            default:
            begin
                wr = b[WORD-1];
                if (wr) val = a;
            end
        endcase
        if (wr) reg_copy[ins.dest_reg] = val;
        res.wrote         = wr;
        res.written_reg   = ins.dest_reg;
        res.written_value = reg_copy[ins.dest_reg];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++) reg_copy[i] = '0;
            expected_writebacks.delete();
            mismatches         = 0;
            writebacks_pending = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_writebacks.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result beat wrote=%0b reg=%0d value=%h",
                                 $time, result.wrote, result.written_reg,
                                 result.written_value);
                end
                else
                begin
                    want = expected_writebacks.pop_front();
                    if (result.wrote !== want.wrote ||
                        result.written_reg !== want.written_reg ||
                        result.written_value !== want.written_value)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: result mismatch expected wrote=%0b reg=%0d ",
                                      "value=%h, got wrote=%0b reg=%0d value=%h"},
                                     $time, want.wrote, want.written_reg,
                                     want.written_value, result.wrote,
                                     result.written_reg, result.written_value);
                    end
                end
            end
            if (instr_valid && instr_ready)
                expected_writebacks.push_back(execute_instr(instr));
            writebacks_pending = expected_writebacks.size();
        end
    end

endmodule

>>> tb/sixteen_op_register_execute_unit_top_test.sv
`timescale 1ns / 1ps

module sixteen_op_register_execute_unit_top_test;
    import sorxu_pkg::*;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    instr_valid  = 1'b0;
    logic    instr_ready;
    instr_t  instr        = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;
    int      mismatches;
    int      writebacks_pending;
    bit      idling_on    = 1'b1;

    always #6 clk = ~clk;

    sixteen_op_register_execute_unit_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .instr_valid  (instr_valid),
        .instr_ready  (instr_ready),
        .instr        (instr),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    execute_result_check u_check (
        .clk                (clk),
        .rst_n              (rst_n),
        .instr_valid        (instr_valid),
        .instr_ready        (instr_ready),
        .instr              (instr),
        .result_valid       (result_valid),
        .result_ready       (result_ready),
        .result             (result),
        .mismatches         (mismatches),
        .writebacks_pending (writebacks_pending)
    );

    always @(posedge clk)
    begin
        if (rst_n)
            result_ready <= !(idling_on && $urandom_range(0, 99) < 11);
    end

    function automatic instr_t make_instr(input cmd_t op, input int d, input int a,
                                          input int b, input int imm);
        instr_t x;
        x.command   = op;
        x.dest_reg  = d[3:0];
        x.src_a_reg = a[3:0];
        x.src_b_reg = b[3:0];
        x.immediate = imm[7:0];
        return x;
    endfunction

    task automatic issue_instr(input instr_t x);
        while (idling_on && $urandom_range(0, 99) < 11)
        begin
            instr_valid <= 1'b0;
            @(posedge clk);
        end
        instr_valid <= 1'b1;
        instr       <= x;
        @(negedge clk);
        while (!instr_ready) @(negedge clk);
        @(posedge clk);
    endtask

    initial
    begin
        instr_t directed [$];
        instr_t x;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed.push_back(make_instr(CMD_SET,   1, 0, 0, 8'hFF));
        directed.push_back(make_instr(CMD_SETH,  1, 0, 0, 8'h80));
        directed.push_back(make_instr(CMD_SET,   2, 0, 0, 8'h00));
        directed.push_back(make_instr(CMD_MOVE,  3, 1, 0, 8'h00));
        directed.push_back(make_instr(CMD_NOT,   4, 2, 0, 8'h00));
        directed.push_back(make_instr(CMD_AND,   5, 1, 4, 8'h00));
        directed.push_back(make_instr(CMD_OR,    6, 1, 2, 8'h00));
        directed.push_back(make_instr(CMD_ADD,   7, 4, 4, 8'h00));
        directed.push_back(make_instr(CMD_SUB,   8, 2, 1, 8'h00));
        directed.push_back(make_instr(CMD_ADDI,  9, 4, 0, 8'h0F));
        directed.push_back(make_instr(CMD_SUBI, 10, 2, 0, 8'hFF));
        directed.push_back(make_instr(CMD_INCIZ, 11, 0, 2, 8'hFF));
        directed.push_back(make_instr(CMD_INCIZ, 11, 0, 1, 8'h0F));
        directed.push_back(make_instr(CMD_DECIN, 12, 0, 1, 8'hF1));
        directed.push_back(make_instr(CMD_DECIN, 12, 0, 2, 8'h0F));
        directed.push_back(make_instr(CMD_MOVEZ, 13, 1, 2, 8'h00));
        directed.push_back(make_instr(CMD_MOVEZ, 13, 4, 1, 8'h00));
        directed.push_back(make_instr(CMD_MOVEX, 14, 4, 1, 8'h00));
        directed.push_back(make_instr(CMD_MOVEX, 14, 1, 2, 8'h00));
        directed.push_back(make_instr(CMD_MOVEP, 15, 1, 2, 8'h00));
        directed.push_back(make_instr(CMD_MOVEP, 15, 4, 1, 8'h00));
        directed.push_back(make_instr(CMD_MOVEN,  0, 4, 1, 8'h00));
        directed.push_back(make_instr(CMD_MOVEN,  0, 1, 11, 8'h00));
        directed.push_back(make_instr(CMD_ADD,   15, 15, 15, 8'h00));
        directed.push_back(make_instr(CMD_SETH,   0, 0, 0, 8'hFF));
        foreach (directed[i]) issue_instr(directed[i]);

        for (int n = 0; n < 650; n++)
        begin
            idling_on = !(n >= 200 && n < 350);
            x.command   = 4'($urandom_range(0, 15));
            x.dest_reg  = 4'($urandom_range(0, 15));
            x.src_a_reg = 4'($urandom_range(0, 15));
            x.src_b_reg = 4'($urandom_range(0, 15));
            x.immediate = 8'($urandom_range(0, 255));
            issue_instr(x);
        end
        instr_valid <= 1'b0;
        idling_on = 1'b1;

        while (writebacks_pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
